// ===== rtl/core/sbad_pkg.sv =====
`timescale 1ns / 1ps

package sbad_pkg;

  localparam int MAX_DIGITS = 10;
  localparam int VALUE_W    = 32;
  localparam int CHAR_W     = 6;
  localparam int CNT_W      = $clog2(VALUE_W);
  localparam int DIG_W      = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = CHAR_W'(48);
  localparam logic [CHAR_W-1:0] ASCII_MINUS = CHAR_W'(45);

  // 10**MAX_DIGITS, saturated at 2**VALUE_W
  function automatic logic [VALUE_W:0] pow10_sat();
    logic [VALUE_W+7:0] p;
    p = (VALUE_W+8)'(1);
    for (int i = 0; i < MAX_DIGITS; i++) begin
      p = (VALUE_W+8)'(p * 10);
      if (p > ((VALUE_W+8)'(1) << VALUE_W)) begin
        p = (VALUE_W+8)'(1) << VALUE_W;
      end
    end
    return p[VALUE_W:0];
  endfunction

  localparam logic [VALUE_W:0] POW10_SAT = pow10_sat();

  typedef struct packed {
    logic load;
    logic shift;
    logic skip;
    logic emit_sign;
    logic emit_digit;
  } sbad_cmd_t;

  typedef struct packed {
    logic bits_done;
    logic neg;
    logic lead_zero;
    logic last_digit;
  } sbad_status_t;

endpackage

// ===== rtl/core/sbad_datapath.sv =====
`timescale 1ns / 1ps

module sbad_datapath import sbad_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic signed [VALUE_W-1:0] value,
  input  sbad_cmd_t                 cmd,
  output sbad_status_t              status,
  output logic                      strobe,
  output logic [CHAR_W-1:0]         ascii_char,
  output logic                      last_char
);

  logic [VALUE_W-1:0]             mag;
  logic [MAX_DIGITS-1:0][3:0]     bcd;
  logic [CNT_W-1:0]               bit_cnt;
  logic [DIG_W-1:0]               dig_idx;
  logic                           neg;
  logic                           ovf;

  logic [VALUE_W-1:0]             raw;
  logic [VALUE_W-1:0]             mag_in;
  logic [MAX_DIGITS-1:0][3:0]     bcd_adj;
  logic [4*MAX_DIGITS-1:0]        adj_flat;
  logic [MAX_DIGITS-1:0][3:0]     bcd_next;
  logic [3:0]                     cur_digit;

  assign raw    = VALUE_W'(value);
  assign mag_in = raw[VALUE_W-1] ? (~raw + VALUE_W'(1)) : raw;

  // add-3 correction per digit, then shift one magnitude bit in
  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      bcd_adj[i] = (bcd[i] >= 4'd5) ? (bcd[i] + 4'd3) : bcd[i];
    end
  end

  assign adj_flat = bcd_adj;
  assign bcd_next = {adj_flat[4*MAX_DIGITS-2:0], mag[VALUE_W-1]};

  assign cur_digit = bcd[dig_idx];

  assign status.bits_done  = (bit_cnt == CNT_W'(VALUE_W-1));
  assign status.neg        = neg;
  assign status.last_digit = (dig_idx == '0);
  assign status.lead_zero  = (cur_digit == 4'd0) && !ovf && (dig_idx != '0);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag     <= mag_in;
      bcd     <= '0;
      bit_cnt <= '0;
      neg     <= raw[VALUE_W-1];
      ovf     <= ({1'b0, mag_in} >= POW10_SAT);
      dig_idx <= DIG_W'(MAX_DIGITS-1);
    end else if (cmd.shift) begin
      mag     <= {mag[VALUE_W-2:0], 1'b0};
      bcd     <= bcd_next;
      bit_cnt <= bit_cnt + CNT_W'(1);
    end else if (cmd.skip || (cmd.emit_digit && dig_idx != '0)) begin
      dig_idx <= dig_idx - DIG_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.emit_sign || cmd.emit_digit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_sign) begin
      ascii_char <= ASCII_MINUS;
      last_char  <= 1'b0;
    end else if (cmd.emit_digit) begin
      ascii_char <= ASCII_ZERO + CHAR_W'(cur_digit);
      last_char  <= (dig_idx == '0);
    end
  end

endmodule

// ===== rtl/core/sbad_ctrl.sv =====
`timescale 1ns / 1ps

module sbad_ctrl import sbad_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  output logic         busy,
  input  sbad_status_t status,
  output sbad_cmd_t    cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CONV = 3'd1;
  localparam logic [2:0] S_SIGN = 3'd2;
  localparam logic [2:0] S_SKIP = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_CONV;
        end
      end
      S_CONV: begin
        cmd.shift = 1'b1;
        if (status.bits_done) begin
          state_next = status.neg ? S_SIGN : S_SKIP;
        end
      end
      S_SIGN: begin
        cmd.emit_sign = 1'b1;
        state_next    = S_SKIP;
      end
      S_SKIP: begin
        if (status.lead_zero) begin
          cmd.skip = 1'b1;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        cmd.emit_digit = 1'b1;
        if (status.last_digit) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/core/signed_binary_to_ascii_decimal_top.sv =====
`timescale 1ns / 1ps

// signed 32-bit integer to decimal ascii text
// input: value is taken at a clock edge where start is high and busy is low
// output: one character per beat on ascii_char, marked by a one-cycle strobe,
//   most significant digit first, '-' first for negative values, no leading
//   zeros; last_char marks the final character of the number
// the receiver cannot stall: every strobe beat is taken as it comes
// timing: after the accept, shift-add-3 conversion (one bit per
//   cycle through the bcd register), then a minus sign for a negative value,
//   then a scan past leading zeros and the digits, one per character;
//   busy falls in the cycle that carries the last strobe
// a full item includes the accept cycle and, for a negative value, the minus
//   sign; the bcd conversion loop and the leading zero scan set its length
// one item at a time; busy stays high until the last character is out
// reset: synchronous, returns the controller to idle and drops strobe; an item
//   in progress is abandoned

module signed_binary_to_ascii_decimal_top import sbad_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [VALUE_W-1:0] value,
  output logic                      strobe,
  output logic [CHAR_W-1:0]         ascii_char,
  output logic                      last_char
);

  sbad_cmd_t    cmd;
  sbad_status_t status;

  sbad_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  sbad_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .value      (value),
    .cmd        (cmd),
    .status     (status),
    .strobe     (strobe),
    .ascii_char (ascii_char),
    .last_char  (last_char)
  );

endmodule
